@@ rtl/source_address_port_filter_assert.svh @@
// Assertion macros shared by the source address and port filter RTL.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef SOURCE_ADDRESS_PORT_FILTER_ASSERT_SVH
`define SOURCE_ADDRESS_PORT_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SAPF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sapf assertion failed");

// Next-cycle implication, disabled during reset.
`define SAPF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sapf assertion failed");

`endif

@@ rtl/sapf_pkg.sv @@
// Package for the source address and port filter: sizes, codes, types.
// No dependencies; used by sapf_ctrl, sapf_dp and the top level.
package sapf_pkg;

  localparam int MaxEntries = 128;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int KeyW       = 48;

  localparam logic       ActClassify = 1'b0;
  localparam logic       ActAdd      = 1'b1;
  localparam logic [7:0] ProtoTcp    = 8'd6;
  localparam logic [7:0] ProtoUdp    = 8'd17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic add_commit;
    logic scan_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_search;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/sapf_ctrl.sv @@
// Controller state machine of the source address and port filter.
// Depends on sapf_pkg; drives command signals into sapf_dp.
module sapf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sapf_pkg::sts_t  sts,
  output sapf_pkg::cmd_t  cmd
);

  sapf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sapf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sapf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sapf_pkg::ST_DECODE;
      end
      sapf_pkg::ST_DECODE: begin
        if (sts.is_add) begin
          state_nxt = sapf_pkg::ST_ADD;
        end else if (sts.is_search) begin
          state_nxt = sapf_pkg::ST_SCAN;
        end else begin
          state_nxt = sapf_pkg::ST_FIN;
        end
      end
      sapf_pkg::ST_ADD:  state_nxt = sapf_pkg::ST_FIN;
      sapf_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = sapf_pkg::ST_FIN;
      end
      sapf_pkg::ST_FIN: begin
        if (sts.out_free) state_nxt = sapf_pkg::ST_IDLE;
      end
      default: state_nxt = sapf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      sapf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      sapf_pkg::ST_DECODE: ;
      sapf_pkg::ST_ADD:    cmd.add_commit = 1'b1;
      sapf_pkg::ST_SCAN:   cmd.scan_en = !sts.scan_done;
      sapf_pkg::ST_FIN:    cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/sapf_dp.sv @@
// Datapath of the source address and port filter: item latch, entry memory,
// scan compare, mode register and result register. Depends on sapf_pkg.
`include "source_address_port_filter_assert.svh"

module sapf_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_action,
  input  logic [7:0]      in_protocol,
  input  logic [31:0]     in_source_address,
  input  logic [15:0]     in_source_port,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_accept,
  output logic            out_matched,
  output logic            out_add_refused,
  input  sapf_pkg::cmd_t  cmd,
  output sapf_pkg::sts_t  sts
);

  logic [sapf_pkg::KeyW-1:0] mem [sapf_pkg::MaxEntries];

  logic                      mode_r;
  logic                      action_r;
  logic [7:0]                proto_r;
  logic [sapf_pkg::KeyW-1:0] key_r;
  logic [sapf_pkg::CntW-1:0] count_r;
  logic [sapf_pkg::CntW-1:0] idx_r;
  logic                      rd_vld_r;
  logic [sapf_pkg::KeyW-1:0] rd_data_r;
  logic                      hit_r;
  logic                      refused_r;
  logic                      out_valid_r;
  logic                      out_accept_r;
  logic                      out_matched_r;
  logic                      out_refused_r;

  logic full;
  logic issue;
  logic search;
  logic accept_nxt;

  assign full   = (count_r == sapf_pkg::CntW'(sapf_pkg::MaxEntries));
  assign issue  = cmd.scan_en && (idx_r < count_r);
  assign search = (action_r == sapf_pkg::ActClassify) &&
                  ((proto_r == sapf_pkg::ProtoTcp) || (proto_r == sapf_pkg::ProtoUdp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // latch the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      proto_r  <= in_protocol;
      key_r    <= {in_source_address, in_source_port};
    end
  end

  // append an entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.add_commit && !full) begin
      count_r <= count_r + sapf_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_commit && !full) begin
      mem[count_r[sapf_pkg::IdxW-1:0]] <= key_r;
    end
    if (issue) begin
      rd_data_r <= mem[idx_r[sapf_pkg::IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      refused_r <= full;
    end
  end

  // scan: read one entry a cycle, compare it the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cmd.load) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue) idx_r <= idx_r + sapf_pkg::CntW'(1);
      if (rd_vld_r && (rd_data_r == key_r)) hit_r <= 1'b1;
    end
  end

  always_comb begin
    if (action_r == sapf_pkg::ActAdd) begin
      accept_nxt = 1'b0;
    end else if (search) begin
      accept_nxt = mode_r ? hit_r : !hit_r;
    end else begin
      accept_nxt = !mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accept_r  <= accept_nxt;
      out_matched_r <= search && hit_r;
      out_refused_r <= (action_r == sapf_pkg::ActAdd) && refused_r;
    end
  end

  assign sts.is_add    = (action_r == sapf_pkg::ActAdd);
  assign sts.is_search = search;
  assign sts.scan_done = hit_r || (!rd_vld_r && (idx_r >= count_r));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_accept      = out_accept_r;
  assign out_matched     = out_matched_r;
  assign out_add_refused = out_refused_r;

  `SAPF_ASSERT_IMP(a_count_bound, 1'b1, count_r <= sapf_pkg::CntW'(sapf_pkg::MaxEntries))
  `SAPF_ASSERT_NXT(a_full_holds, cmd.add_commit && full, full)
  `SAPF_ASSERT_IMP(a_refused_alone, out_valid_r && out_refused_r,
                   !out_accept_r && !out_matched_r)
  `SAPF_ASSERT_IMP(a_idx_bound, 1'b1, idx_r <= count_r)

endmodule

@@ rtl/source_address_port_filter.sv @@
// Top level of the source address and port filter.
// Depends on sapf_pkg, sapf_ctrl and sapf_dp.
//
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  in       | in_valid/in_stall, action, protocol, addr, port | item in
//  out      | out_valid/out_stall, accept, matched, refused  | word out
//  cfg      | cfg_wr_en, cfg_wr_data (allow_list_mode)       | write only
//
// One word at a time. An add passes through the decode, add and final states;
// a TCP/UDP lookup scans the entry memory one entry per cycle through its
// single read port and stops early on a hit; other protocols go from the
// decode state straight to the final state.
// Reset (rst_n low, synchronous) empties the table and selects block-list mode;
// memory contents are not cleared, only the fill count is.
// A stalled result stays in the output register while the next word is taken in;
// that word then waits in its final state until the output register frees.
module source_address_port_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_protocol,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_source_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accept,
  output logic        out_matched,
  output logic        out_add_refused
);

  // command and status between controller and datapath
  sapf_pkg::cmd_t cmd;
  sapf_pkg::sts_t sts;

  sapf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sapf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_action         (in_action),
    .in_protocol       (in_protocol),
    .in_source_address (in_source_address),
    .in_source_port    (in_source_port),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accept        (out_accept),
    .out_matched       (out_matched),
    .out_add_refused   (out_add_refused),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
